// ===== design/isv_pkg.sv =====
// isv_pkg: shared types, constants and helpers of the input string validator
// holds register indexes, verdict codes, byte patterns and the window match helper
// no dependencies
package isv_pkg;

	localparam int unsigned LENGTH_LIMIT_MAX = 65535;
	localparam int unsigned HIST_DEPTH = 10;
	localparam int unsigned WIN_DEPTH = HIST_DEPTH + 1;
	localparam int unsigned COUNT_W = $clog2(64'(LENGTH_LIMIT_MAX) + 64'd2);
	localparam int unsigned LEN_W = 17;
	localparam int unsigned LIMIT_W = 16;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 64;
	localparam int unsigned MAP_W = 256;
	localparam int unsigned PAT_W = 8 * WIN_DEPTH;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd4095;

	localparam logic [PAT_W-1:0] PAT_DOTSLASH = PAT_W'("../");
	localparam logic [PAT_W-1:0] PAT_DOTBACK = PAT_W'("..\\");
	localparam logic [PAT_W-1:0] PAT_SCRIPT = PAT_W'("<script");
	localparam logic [PAT_W-1:0] PAT_JS = PAT_W'("javascript:");
	localparam int unsigned LEN_DOTSLASH = 3;
	localparam int unsigned LEN_DOTBACK = 3;
	localparam int unsigned LEN_SCRIPT = 7;
	localparam int unsigned LEN_JS = 11;

	typedef logic [7:0] byte_t;
	typedef byte_t [HIST_DEPTH-1:0] hist_t;
	typedef byte_t [WIN_DEPTH-1:0] window_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LENGTH_LIMIT = 3'd0,
		CFG_CHARSET_EN   = 3'd1,
		CFG_MAP_0        = 3'd2,
		CFG_MAP_1        = 3'd3,
		CFG_MAP_2        = 3'd4,
		CFG_MAP_3        = 3'd5
	} cfg_idx_t;

	typedef enum logic [2:0] {
		VERDICT_VALID     = 3'd0,
		VERDICT_TOO_LONG  = 3'd1,
		VERDICT_EMPTY     = 3'd2,
		VERDICT_BAD_CHAR  = 3'd3,
		VERDICT_TRAVERSAL = 3'd4,
		VERDICT_SCRIPT    = 3'd5
	} verdict_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] length_limit;
		logic               charset_en;
		logic [MAP_W-1:0]   allowed_map;
	} cfg_t;

	typedef struct packed {
		logic traversal;
		logic script;
	} hits_t;

	// window entry k is the byte k places back, entry 0 the current byte
	function automatic logic match_tail(window_t win, logic [PAT_W-1:0] pat,
			int unsigned len);
		logic ok;
		ok = 1'b1;
		for (int unsigned k = 0; k < WIN_DEPTH; k++) begin
			if (k < len && win[k] != pat[8*k +: 8]) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

endpackage

// ===== design/isv_stream_if.sv =====
// isv_in_if, isv_out_if: valid/ready channels of the input string validator
// depends on isv_pkg for the payload types
interface isv_in_if;
	logic                valid;
	logic                ready;
	logic                kind;
	isv_pkg::byte_t      char_byte;

	modport source (output valid, output kind, output char_byte, input ready);
	modport sink (input valid, input kind, input char_byte, output ready);
endinterface

interface isv_out_if;
	logic                        valid;
	logic                        ready;
	logic [2:0]                  verdict;
	logic [isv_pkg::LEN_W-1:0]   string_length;

	modport source (output valid, output verdict, output string_length, input ready);
	modport sink (input valid, input verdict, input string_length, output ready);
endinterface

// ===== design/isv_cfg_regs.sv =====
// isv_cfg_regs: configuration registers (length limit, charset enable, allowed map)
// depends on isv_pkg
module isv_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [isv_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [isv_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output isv_pkg::cfg_t                    cfg
);

	logic [isv_pkg::LIMIT_W-1:0] limit_q;
	logic                        enable_q;
	logic [isv_pkg::MAP_W-1:0]   map_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= isv_pkg::LIMIT_RESET;
			enable_q <= 1'b0;
			map_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				isv_pkg::CFG_LENGTH_LIMIT: limit_q <= cfg_wdata[isv_pkg::LIMIT_W-1:0];
				isv_pkg::CFG_CHARSET_EN:   enable_q <= cfg_wdata[0];
				isv_pkg::CFG_MAP_0:        map_q[0*64 +: 64] <= cfg_wdata;
				isv_pkg::CFG_MAP_1:        map_q[1*64 +: 64] <= cfg_wdata;
				isv_pkg::CFG_MAP_2:        map_q[2*64 +: 64] <= cfg_wdata;
				isv_pkg::CFG_MAP_3:        map_q[3*64 +: 64] <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign cfg.length_limit = limit_q;
	assign cfg.charset_en   = enable_q;
	assign cfg.allowed_map  = map_q;

endmodule

// ===== design/isv_pattern_det.sv =====
// isv_pattern_det: matches traversal and script patterns ending at the current byte
// depends on isv_pkg for the patterns and the window match helper
module isv_pattern_det (
	input  isv_pkg::byte_t  cur_byte,
	input  isv_pkg::hist_t  hist,
	output isv_pkg::hits_t  hits
);

	isv_pkg::window_t win;

	always_comb begin
		win[0] = cur_byte;
		for (int unsigned k = 1; k < isv_pkg::WIN_DEPTH; k++) begin
			win[k] = hist[k-1];
		end
	end

	assign hits.traversal =
		isv_pkg::match_tail(win, isv_pkg::PAT_DOTSLASH, isv_pkg::LEN_DOTSLASH) ||
		isv_pkg::match_tail(win, isv_pkg::PAT_DOTBACK, isv_pkg::LEN_DOTBACK);
	assign hits.script =
		isv_pkg::match_tail(win, isv_pkg::PAT_SCRIPT, isv_pkg::LEN_SCRIPT) ||
		isv_pkg::match_tail(win, isv_pkg::PAT_JS, isv_pkg::LEN_JS);

endmodule

// ===== design/input_string_validator.sv =====
// input_string_validator: top level, input register, string state and verdict register
// depends on isv_pkg, isv_stream_if, isv_cfg_regs, isv_pattern_det
//
// usage:
//   item channel (sink): one beat per string byte (kind 0) or terminator (kind 1).
//   result channel (source): one beat per terminator with the verdict and the
//   byte count, saturating one above the length limit constant.
//   configuration: write cfg_we/cfg_index/cfg_wdata while no string is in flight;
//   index 0 length limit, 1 charset enable, 2..5 allowed map words.
// timing:
//   one item per cycle sustained while no terminator stalls. an accepted item
//   waits in the input register, then updates the string state; a terminator
//   loads the result register as it leaves the input register, raising its result beat.
//   the rate is set by the single state update between the input register and
//   the string state, which takes one item each cycle unless a terminator stalls.
// stall:
//   while a result waits unread, bytes keep flowing; a following terminator
//   waits in the input register, and ready drops only while that register
//   holds a terminator that cannot move on.
// reset:
//   arst_n clears all string state and both valid flags and loads register
//   defaults (limit 4095, charset check off, map all zero).
module input_string_validator (
	input  logic                             clk,
	input  logic                             arst_n,
	isv_in_if.sink                           item,
	isv_out_if.source                        result,
	input  logic                             cfg_we,
	input  logic [isv_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [isv_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	localparam logic [isv_pkg::COUNT_W-1:0] COUNT_SAT =
		isv_pkg::COUNT_W'(64'(isv_pkg::LENGTH_LIMIT_MAX) + 64'd1);
	localparam logic [isv_pkg::COUNT_W-1:0] LIMIT_CAP =
		isv_pkg::COUNT_W'(isv_pkg::LENGTH_LIMIT_MAX);

	isv_pkg::cfg_t   cfg;
	isv_pkg::hits_t  hits;

	logic            valid_s1;
	logic            kind_s1;
	isv_pkg::byte_t  char_s1;

	isv_pkg::hist_t                hist_q;
	logic [isv_pkg::COUNT_W-1:0]   count_q;
	logic                          bad_q;
	logic                          trav_q;
	logic                          scr_q;

	logic                          out_valid_q;
	isv_pkg::verdict_t             verdict_q;
	logic [isv_pkg::LEN_W-1:0]     length_q;

	logic                          advance;
	logic                          take_item;
	logic                          char_ok;
	logic [isv_pkg::COUNT_W-1:0]   limit_eff;
	isv_pkg::verdict_t             verdict_d;

	isv_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	isv_pattern_det u_pat (
		.cur_byte (char_s1),
		.hist     (hist_q),
		.hits     (hits)
	);

	// a byte never blocks; a terminator needs the result register free
	assign advance   = valid_s1 && (!kind_s1 || !out_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign take_item = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_item) begin
			kind_s1 <= item.kind;
			char_s1 <= item.char_byte;
		end
	end

	assign char_ok = !cfg.charset_en || cfg.allowed_map[char_s1];

	always_comb begin
		if (64'(cfg.length_limit) > 64'(isv_pkg::LENGTH_LIMIT_MAX)) begin
			limit_eff = LIMIT_CAP;
		end else begin
			limit_eff = isv_pkg::COUNT_W'(cfg.length_limit);
		end
	end

	always_comb begin
		if (count_q > limit_eff) begin
			verdict_d = isv_pkg::VERDICT_TOO_LONG;
		end else if (count_q == '0) begin
			verdict_d = isv_pkg::VERDICT_EMPTY;
		end else if (bad_q) begin
			verdict_d = isv_pkg::VERDICT_BAD_CHAR;
		end else if (trav_q) begin
			verdict_d = isv_pkg::VERDICT_TRAVERSAL;
		end else if (scr_q) begin
			verdict_d = isv_pkg::VERDICT_SCRIPT;
		end else begin
			verdict_d = isv_pkg::VERDICT_VALID;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q  <= '0;
			count_q <= '0;
			bad_q   <= 1'b0;
			trav_q  <= 1'b0;
			scr_q   <= 1'b0;
		end else if (advance) begin
			if (kind_s1) begin
				hist_q  <= '0;
				count_q <= '0;
				bad_q   <= 1'b0;
				trav_q  <= 1'b0;
				scr_q   <= 1'b0;
			end else begin
				hist_q <= {hist_q[isv_pkg::HIST_DEPTH-2:0], char_s1};
				if (count_q != COUNT_SAT) begin
					count_q <= count_q + 1'b1;
				end
				bad_q  <= bad_q || !char_ok;
				trav_q <= trav_q || hits.traversal;
				scr_q  <= scr_q || hits.script;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && kind_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && kind_s1) begin
			verdict_q <= verdict_d;
			length_q  <= isv_pkg::LEN_W'(count_q);
		end
	end

	assign result.valid         = out_valid_q;
	assign result.verdict       = verdict_q;
	assign result.string_length = length_q;

	// a fresh result beat only follows a terminator leaving the input register
	a_result_from_term: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && kind_s1))
		else $error("result beat without terminator");

	// string state is clear right after a terminator
	a_clear_after_term: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && kind_s1) |=> (count_q == '0 && !bad_q && !trav_q && !scr_q
			&& hist_q == '0))
		else $error("string state not cleared");

	// the byte count never passes saturation
	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_SAT)
		else $error("byte count beyond saturation");

	// ready drops only with a terminator stuck behind an unread result
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> (valid_s1 && kind_s1 && out_valid_q && !result.ready))
		else $error("input stalled without cause");

	// empty verdict carries zero length
	a_empty_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && verdict_q == isv_pkg::VERDICT_EMPTY) |-> length_q == '0)
		else $error("empty verdict with nonzero length");

endmodule

// ===== verif/tb_input_string_validator.sv =====
`timescale 1ns / 100ps
// tb_input_string_validator: self-checking bench for the input string validator
// sends strings as byte beats plus a terminator, checks every verdict and length against an
// in-bench model of the checks or a directed expectation; depends on isv_pkg, isv_stream_if and the rtl
module tb_input_string_validator;

	localparam int DRAIN_TAIL = 6;
	localparam int RANDOM_ITEMS = 1800;
	localparam int RANDOM_PHASES = 8;
	localparam logic [isv_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
	localparam logic [isv_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
	localparam logic [isv_pkg::LEN_W-1:0] COUNT_SAT =
		isv_pkg::LEN_W'(isv_pkg::LENGTH_LIMIT_MAX + 1);
	localparam logic [isv_pkg::CFG_DATA_W-1:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		isv_pkg::verdict_t           verdict;
		logic [isv_pkg::LEN_W-1:0]   len;
	} verdict_rec_t;

	typedef enum bit {ROW_WRITE, ROW_STRING} row_op_t;

	typedef struct {
		row_op_t                          op;
		logic [isv_pkg::CFG_IDX_W-1:0]    idx;
		logic [isv_pkg::CFG_DATA_W-1:0]   wdata;
		int                               n;
		logic [95:0]                      body;
		bit                               typed;
		isv_pkg::verdict_t                verdict;
		int                               len;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [isv_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [isv_pkg::CFG_DATA_W-1:0] cfg_wdata;

	isv_in_if item_ch ();
	isv_out_if result_ch ();

	input_string_validator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// shadow of the string state and the registers
	isv_pkg::byte_t str_hist [isv_pkg::HIST_DEPTH];
	logic [isv_pkg::LEN_W-1:0] str_count;
	bit bad_seen;
	bit trav_seen;
	bit script_seen;
	logic [isv_pkg::LIMIT_W-1:0] lim_reg;
	bit cs_en_reg;
	logic [isv_pkg::MAP_W-1:0] allowed_map_reg;

	verdict_rec_t pending_verdicts [$];
	isv_pkg::byte_t str_buf [$];
	int mismatches = 0;
	int items_sent = 0;
	int src_gap_max = 12;
	int sink_gap_max = 12;
	int hold_ticks = 0;

	string attack_pats [4] = '{"../", "..\\", "<script", "javascript:"};
	string char_pool = "./\\<:javascript";

	dir_row_t directed_rows [14] = '{
		'{ROW_STRING, isv_pkg::CFG_LENGTH_LIMIT, 64'd0, 0, 96'd0, 1'b1,
			isv_pkg::VERDICT_EMPTY, 0},
		'{ROW_STRING, isv_pkg::CFG_LENGTH_LIMIT, 64'd0, 3, 96'h00FF01, 1'b1,
			isv_pkg::VERDICT_VALID, 3},
		'{ROW_STRING, isv_pkg::CFG_LENGTH_LIMIT, 64'd0, 3, "..\\", 1'b1,
			isv_pkg::VERDICT_TRAVERSAL, 3},
		'{ROW_STRING, isv_pkg::CFG_LENGTH_LIMIT, 64'd0, 7, "<script", 1'b1,
			isv_pkg::VERDICT_SCRIPT, 7},
		'{ROW_WRITE, isv_pkg::CFG_LENGTH_LIMIT, 64'd2, 0, 96'd0, 1'b0,
			isv_pkg::VERDICT_VALID, 0},
		'{ROW_WRITE, isv_pkg::CFG_CHARSET_EN, 64'd1, 0, 96'd0, 1'b0,
			isv_pkg::VERDICT_VALID, 0},
		'{ROW_WRITE, isv_pkg::CFG_MAP_0, ~64'd1, 0, 96'd0, 1'b0,
			isv_pkg::VERDICT_VALID, 0},
		'{ROW_WRITE, isv_pkg::CFG_MAP_1, ALL_ONES, 0, 96'd0, 1'b0,
			isv_pkg::VERDICT_VALID, 0},
		'{ROW_WRITE, isv_pkg::CFG_MAP_2, ALL_ONES, 0, 96'd0, 1'b0,
			isv_pkg::VERDICT_VALID, 0},
		'{ROW_WRITE, isv_pkg::CFG_MAP_3, ALL_ONES, 0, 96'd0, 1'b0,
			isv_pkg::VERDICT_VALID, 0},
		'{ROW_WRITE, CFG_SPARE_A, 64'd0, 0, 96'd0, 1'b0,
			isv_pkg::VERDICT_VALID, 0},
		'{ROW_STRING, isv_pkg::CFG_LENGTH_LIMIT, 64'd0, 3, "abc", 1'b1,
			isv_pkg::VERDICT_TOO_LONG, 3},
		'{ROW_STRING, isv_pkg::CFG_LENGTH_LIMIT, 64'd0, 1, 96'h00, 1'b1,
			isv_pkg::VERDICT_BAD_CHAR, 1},
		'{ROW_STRING, isv_pkg::CFG_LENGTH_LIMIT, 64'd0, 2, 96'hFF2E, 1'b0,
			isv_pkg::VERDICT_VALID, 0}
	};

	function automatic void clear_string();
		foreach (str_hist[i]) str_hist[i] = '0;
		str_count = '0;
		bad_seen = 1'b0;
		trav_seen = 1'b0;
		script_seen = 1'b0;
	endfunction

	// pattern ends at the current byte, older bytes taken from the history
	function automatic bit tail_is(isv_pkg::byte_t cur, string pat);
		int n;
		n = pat.len();
		if (pat[n-1] != cur) return 1'b0;
		for (int i = 1; i < n; i++) begin
			if (pat[n-1-i] != str_hist[i-1]) return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic bit screen_item(bit kind, isv_pkg::byte_t ch,
			output verdict_rec_t rec);
		int unsigned eff_limit;
		rec = '{isv_pkg::VERDICT_VALID, '0};
		if (!kind) begin
			if (str_count < COUNT_SAT) str_count++;
			if (cs_en_reg && !allowed_map_reg[ch]) bad_seen = 1'b1;
			if (tail_is(ch, attack_pats[0]) || tail_is(ch, attack_pats[1])) trav_seen = 1'b1;
			if (tail_is(ch, attack_pats[2]) || tail_is(ch, attack_pats[3])) script_seen = 1'b1;
			for (int i = isv_pkg::HIST_DEPTH - 1; i > 0; i--) str_hist[i] = str_hist[i-1];
			str_hist[0] = ch;
			return 1'b0;
		end
		eff_limit = (lim_reg > isv_pkg::LENGTH_LIMIT_MAX) ? isv_pkg::LENGTH_LIMIT_MAX : lim_reg;
		if (str_count > eff_limit) rec.verdict = isv_pkg::VERDICT_TOO_LONG;
		else if (str_count == 0) rec.verdict = isv_pkg::VERDICT_EMPTY;
		else if (bad_seen) rec.verdict = isv_pkg::VERDICT_BAD_CHAR;
		else if (trav_seen) rec.verdict = isv_pkg::VERDICT_TRAVERSAL;
		else if (script_seen) rec.verdict = isv_pkg::VERDICT_SCRIPT;
		rec.len = str_count;
		clear_string();
		return 1'b1;
	endfunction

	task automatic write_reg(logic [isv_pkg::CFG_IDX_W-1:0] idx,
			logic [isv_pkg::CFG_DATA_W-1:0] d);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= d;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			isv_pkg::CFG_LENGTH_LIMIT: lim_reg = d[isv_pkg::LIMIT_W-1:0];
			isv_pkg::CFG_CHARSET_EN: cs_en_reg = d[0];
			isv_pkg::CFG_MAP_0: allowed_map_reg[63:0] = d;
			isv_pkg::CFG_MAP_1: allowed_map_reg[127:64] = d;
			isv_pkg::CFG_MAP_2: allowed_map_reg[191:128] = d;
			isv_pkg::CFG_MAP_3: allowed_map_reg[255:192] = d;
			default: ;
		endcase
	endtask

	// stop offering beats until every verdict is back
	task automatic settle();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	task automatic push_beat(bit kind, isv_pkg::byte_t ch, bit typed, verdict_rec_t want);
		int gap;
		verdict_rec_t rec;
		gap = $urandom_range(0, src_gap_max);
		@(negedge clk);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.kind <= kind;
		item_ch.char_byte <= ch;
		@(posedge clk);
		while (item_ch.ready !== 1'b1) @(posedge clk);
		items_sent++;
		if (screen_item(kind, ch, rec)) pending_verdicts.push_back(typed ? want : rec);
	endtask

	task automatic send_string(bit typed, verdict_rec_t want);
		foreach (str_buf[j]) push_beat(1'b0, str_buf[j], 1'b0, want);
		push_beat(1'b1, isv_pkg::byte_t'($urandom_range(0, 255)), typed, want);
	endtask

	task automatic build_string(int target);
		string pat;
		int pos;
		str_buf.delete();
		while (str_buf.size() < target) begin
			pat = attack_pats[$urandom_range(0, 3)];
			case ($urandom_range(0, 9))
				0, 1: str_buf.push_back(isv_pkg::byte_t'($urandom_range(0, 255)));
				2, 3: str_buf.push_back(char_pool[$urandom_range(0, char_pool.len() - 1)]);
				4: str_buf.push_back(isv_pkg::byte_t'("a" + $urandom_range(0, 25)));
				7: begin
					// pattern cut short
					for (int i = 0; i < pat.len() - 1; i++) str_buf.push_back(pat[i]);
				end
				8: begin
					// one byte with its case bit flipped
					pos = $urandom_range(0, pat.len() - 1);
					for (int i = 0; i < pat.len(); i++) begin
						str_buf.push_back(i == pos ? pat[i] ^ 8'h20 : pat[i]);
					end
				end
				default: begin
					for (int i = 0; i < pat.len(); i++) str_buf.push_back(pat[i]);
				end
			endcase
		end
	endtask

	task automatic pick_settings(int ph);
		int lim;
		logic [isv_pkg::CFG_DATA_W-1:0] word;
		case (ph % 4)
			0: begin src_gap_max = 12; sink_gap_max = 12; end
			1: begin src_gap_max = 0; sink_gap_max = 0; end
			2: begin src_gap_max = 3; sink_gap_max = 12; end
			default: begin src_gap_max = 12; sink_gap_max = 0; end
		endcase
		case (ph % 5)
			0: lim = 0;
			1: lim = isv_pkg::LENGTH_LIMIT_MAX;
			2: lim = $urandom_range(1, 16);
			3: lim = 4095;
			default: lim = $urandom_range(0, 65535);
		endcase
		write_reg(isv_pkg::CFG_LENGTH_LIMIT,
			{32'($urandom), 16'($urandom), isv_pkg::LIMIT_W'(lim)});
		write_reg(isv_pkg::CFG_CHARSET_EN, {32'($urandom), 31'($urandom), 1'(ph % 3 != 0)});
		for (int k = 0; k < 4; k++) begin
			case ($urandom_range(0, 3))
				0: word = '0;
				1: word = ALL_ONES;
				2: word = ~({$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom});
				default: word = {$urandom, $urandom};
			endcase
			write_reg(isv_pkg::CFG_IDX_W'(isv_pkg::CFG_MAP_0 + k), word);
		end
		write_reg((ph % 2) ? CFG_SPARE_A : CFG_SPARE_B, {$urandom, $urandom});
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Verification failed");
		$finish;
	end

	// result side: random back-pressure, one long hold on request
	initial begin
		int gap;
		verdict_rec_t want;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = $urandom_range(0, sink_gap_max);
			if (hold_ticks > 0) begin
				gap = hold_ticks;
				hold_ticks = 0;
			end
			@(negedge clk);
			if (gap > 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (result_ch.valid !== 1'b1) @(posedge clk);
			if (pending_verdicts.size() == 0) begin
				$error("result beat with no verdict pending: verdict %0d string_length %0d",
					result_ch.verdict, result_ch.string_length);
				mismatches++;
			end else begin
				want = pending_verdicts.pop_front();
				if (result_ch.verdict !== want.verdict) begin
					$error("verdict: expected %0d actual %0d", want.verdict, result_ch.verdict);
					mismatches++;
				end
				if (result_ch.string_length !== want.len) begin
					$error("string_length: expected %0d actual %0d", want.len,
						result_ch.string_length);
					mismatches++;
				end
			end
		end
	end

	initial begin
		dir_row_t row;
		verdict_rec_t want;
		int base;
		int span;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		item_ch.valid = 1'b0;
		item_ch.kind = 1'b0;
		item_ch.char_byte = '0;
		lim_reg = isv_pkg::LIMIT_RESET;
		cs_en_reg = 1'b0;
		allowed_map_reg = '0;
		clear_string();
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		foreach (directed_rows[r]) begin
			row = directed_rows[r];
			if (row.op == ROW_WRITE) begin
				settle();
				write_reg(row.idx, row.wdata);
			end else begin
				str_buf.delete();
				for (int j = 0; j < row.n; j++) str_buf.push_back(row.body[8*(row.n-1-j) +: 8]);
				want = '{row.verdict, isv_pkg::LEN_W'(row.len)};
				send_string(row.typed, want);
			end
		end

		base = items_sent;
		want = '{isv_pkg::VERDICT_VALID, '0};
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			settle();
			pick_settings(ph);
			while (items_sent < base + (ph + 1) * RANDOM_ITEMS / RANDOM_PHASES) begin
				span = (lim_reg <= 20) ? lim_reg + 3 : 24;
				build_string($urandom_range(0, span));
				send_string(1'b0, want);
				if ($urandom_range(0, 15) == 0) settle();
			end
		end

		// long receiver hold while short strings keep coming
		settle();
		hold_ticks = 400;
		src_gap_max = 0;
		repeat (50) begin
			build_string($urandom_range(0, 4));
			send_string(1'b0, want);
		end

		settle();
		if (mismatches == 0 && pending_verdicts.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
